@@ rtl/sbpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the 64-bit popcount function for the
// stream bit population counter. No dependencies.
package sbpc_pkg;

	localparam int LANES        = 4;
	localparam int LANE_W       = 64;
	localparam int LANE_BYTES   = LANE_W / 8;
	localparam int BLOCK_BYTES  = 32;
	localparam int GROUP_BLOCKS = 16;
	localparam int PLANES       = 4;
	localparam int QUEUE_DEPTH  = 4;
	localparam int VB_W         = 6;
	localparam int TOTAL_W      = 64;
	localparam int POP_W        = 7;
	localparam int LSUM_W       = 11;
	localparam int INC_W        = 13;
	localparam int GPOS_W       = $clog2(GROUP_BLOCKS);
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Plane order inside a plane set.
	localparam int PL_ONES   = 0;
	localparam int PL_TWOS   = 1;
	localparam int PL_FOURS  = 2;
	localparam int PL_EIGHTS = 3;

	typedef logic [LANES-1:0][LANE_W-1:0] block_t;
	typedef logic [PLANES-1:0][LANES-1:0][LANE_W-1:0] plane_set_t;
	typedef logic [LANES-1:0][POP_W-1:0] lane_cnt_t;

	// One masked word waiting between the front and the back.
	typedef struct packed {
		block_t blk;
		logic   last;
	} q_item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Balanced adder tree over the 64 bits of one lane.
	function automatic logic [POP_W-1:0] pop64(input logic [LANE_W-1:0] v);
		logic [31:0][1:0] p1;
		logic [15:0][2:0] p2;
		logic [7:0][3:0]  p3;
		logic [3:0][4:0]  p4;
		logic [1:0][5:0]  p5;
		for (int i = 0; i < 32; i++) begin
			p1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 16; i++) begin
			p2[i] = {1'b0, p1[2*i]} + {1'b0, p1[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			p3[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			p4[i] = {1'b0, p3[2*i]} + {1'b0, p3[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			p5[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
		end
		return {1'b0, p5[0]} + {1'b0, p5[1]};
	endfunction

endpackage

@@ rtl/sbpc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input words, masks bytes past the valid count and
// hands masked words to the queue. Depends on sbpc_pkg.
module sbpc_front
	import sbpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                blk_valid,
	output logic                blk_stall,
	input  logic [LANE_W-1:0]   lane_zero,
	input  logic [LANE_W-1:0]   lane_one,
	input  logic [LANE_W-1:0]   lane_two,
	input  logic [LANE_W-1:0]   lane_three,
	input  logic [VB_W-1:0]     valid_bytes,
	input  logic                last_block,
	input  q_stat_t             qstat,
	output logic                push,
	output q_item_t             push_item
);

	logic    hold_v_q;
	q_item_t hold_q;
	block_t  raw;
	block_t  masked;
	logic    accept;

	// The holding register drains into the queue whenever there is room.
	assign push      = hold_v_q && !qstat.full;
	assign blk_stall = hold_v_q && qstat.full;
	assign accept    = blk_valid && !blk_stall;
	assign push_item = hold_q;

	// Byte i counts when it lies inside the block and below the valid count.
	always_comb begin
		raw = {lane_three, lane_two, lane_one, lane_zero};
		for (int l = 0; l < LANES; l++) begin
			for (int b = 0; b < LANE_BYTES; b++) begin
				if ((l * LANE_BYTES + b < BLOCK_BYTES) &&
				    (valid_bytes > VB_W'(l * LANE_BYTES + b))) begin
					masked[l][8*b +: 8] = raw[l][8*b +: 8];
				end else begin
					masked[l][8*b +: 8] = 8'h00;
				end
			end
		end
	end

	// Holding register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (accept) begin
			hold_v_q <= 1'b1;
		end else if (push) begin
			hold_v_q <= 1'b0;
		end
	end

	// Holding register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q.blk  <= masked;
			hold_q.last <= last_block;
		end
	end

endmodule

@@ rtl/sbpc_queue.sv @@
`timescale 1ns / 1ps
// Short first-in first-out queue of masked words between front and back.
// Depends on sbpc_pkg.
module sbpc_queue
	import sbpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output q_item_t pop_item,
	output q_stat_t qstat
);

	q_item_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_item    = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/sbpc_back.sv @@
`timescale 1ns / 1ps
// Back end: carry-save plane update, popcount pipeline, saturating total
// and the output register. Depends on sbpc_pkg.
module sbpc_back
	import sbpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            qstat,
	input  q_item_t            pop_item,
	output logic               pop,
	output logic               total_valid,
	input  logic               total_stall,
	output logic [TOTAL_W-1:0] bit_total
);

	logic                en;
	plane_set_t          planes_q;
	plane_set_t          planes_nxt;
	block_t              carry;
	logic [GPOS_W-1:0]   gpos_q;
	logic                flush;

	logic                v_s1, last_s1, flush_s1;
	block_t              cw_s1;
	plane_set_t          snap_s1;

	logic                v_s2, last_s2;
	lane_cnt_t           cnt16_s2;
	lane_cnt_t           cntp_s2 [PLANES];

	logic                v_s3, last_s3;
	logic [LANES-1:0][LSUM_W-1:0] lsum_s3;

	logic                out_v_q;
	logic [TOTAL_W-1:0]  out_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [INC_W-1:0]    inc;
	logic [TOTAL_W:0]    sum_wide;
	logic [TOTAL_W-1:0]  total_nxt;

	// The whole back pipeline moves when the output register can load.
	assign en          = !out_v_q || !total_stall;
	assign pop         = en && !qstat.empty;
	assign total_valid = out_v_q;
	assign bit_total   = out_q;

	// Bit-sliced add of the word into the planes; carry out is the sixteens word.
	always_comb begin
		block_t c;
		block_t t;
		c = pop_item.blk;
		for (int p = 0; p < PLANES; p++) begin
			t             = planes_q[p] & c;
			planes_nxt[p] = planes_q[p] ^ c;
			c             = t;
		end
		carry = c;
		flush = pop_item.last || (gpos_q == GPOS_W'(GROUP_BLOCKS - 1));
	end

	// Sum of the weighted lane counts and the saturating running total.
	always_comb begin
		inc = '0;
		for (int l = 0; l < LANES; l++) begin
			inc = inc + INC_W'(lsum_s3[l]);
		end
		sum_wide  = {1'b0, total_q} + (TOTAL_W + 1)'(inc);
		total_nxt = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
	end

	// Control state: planes, group position, stage valids, total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
			gpos_q   <= '0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			flush_s1 <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			v_s3     <= 1'b0;
			last_s3  <= 1'b0;
			out_v_q  <= 1'b0;
			total_q  <= '0;
		end else if (en) begin
			v_s1 <= pop;
			if (pop) begin
				last_s1  <= pop_item.last;
				flush_s1 <= flush;
				planes_q <= flush ? '0 : planes_nxt;
				gpos_q   <= flush ? '0 : gpos_q + 1'b1;
			end
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			out_v_q <= v_s3 && last_s3;
			if (v_s3) begin
				total_q <= last_s3 ? '0 : total_nxt;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en) begin
			if (pop) begin
				cw_s1   <= carry;
				snap_s1 <= planes_nxt;
			end
			for (int l = 0; l < LANES; l++) begin
				cnt16_s2[l] <= pop64(cw_s1[l]);
				for (int p = 0; p < PLANES; p++) begin
					cntp_s2[p][l] <= flush_s1 ? pop64(snap_s1[p][l]) : '0;
				end
			end
			for (int l = 0; l < LANES; l++) begin
				lsum_s3[l] <= {cnt16_s2[l], 4'b0000}
					+ LSUM_W'({cntp_s2[PL_EIGHTS][l], 3'b000})
					+ LSUM_W'({cntp_s2[PL_FOURS][l], 2'b00})
					+ LSUM_W'({cntp_s2[PL_TWOS][l], 1'b0})
					+ LSUM_W'(cntp_s2[PL_ONES][l]);
			end
			if (v_s3 && last_s3) begin
				out_q <= total_nxt;
			end
		end
	end

endmodule

@@ rtl/stream_bit_population_count.sv @@
`timescale 1ns / 1ps
// Throughput: one word per cycle; the back pipeline moves only when its
// output register is free, and the four-entry queue absorbs output stalls.
// Reset (arst_n low, asynchronous) clears the planes, group position,
// running total, queue and all valid flags.
// Top level: front end, queue and back end. Depends on sbpc_pkg.
module stream_bit_population_count
	import sbpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               blk_valid,
	output logic               blk_stall,
	input  logic [LANE_W-1:0]  lane_zero,
	input  logic [LANE_W-1:0]  lane_one,
	input  logic [LANE_W-1:0]  lane_two,
	input  logic [LANE_W-1:0]  lane_three,
	input  logic [VB_W-1:0]    valid_bytes,
	input  logic               last_block,
	output logic               total_valid,
	input  logic               total_stall,
	output logic [TOTAL_W-1:0] bit_total
);

	q_stat_t qstat;
	logic    push;
	logic    pop;
	q_item_t push_item;
	q_item_t pop_item;

	// Accept and mask.
	sbpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.blk_valid   (blk_valid),
		.blk_stall   (blk_stall),
		.lane_zero   (lane_zero),
		.lane_one    (lane_one),
		.lane_two    (lane_two),
		.lane_three  (lane_three),
		.valid_bytes (valid_bytes),
		.last_block  (last_block),
		.qstat       (qstat),
		.push        (push),
		.push_item   (push_item)
	);

	// Decoupling queue.
	sbpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	// Count and total.
	sbpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop_item    (pop_item),
		.pop         (pop),
		.total_valid (total_valid),
		.total_stall (total_stall),
		.bit_total   (bit_total)
	);

endmodule

@@ rtl/sbpc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the stream bit population counter, and the bind
// that attaches them to the top level. Depends on sbpc_pkg.
module sbpc_checker
	import sbpc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               blk_valid,
	input logic               blk_stall,
	input logic               last_block,
	input logic               total_valid,
	input logic               total_stall,
	input logic [TOTAL_W-1:0] bit_total
);

	// Holding register, queue, three back stages and the output register.
	localparam int MAX_OPEN = QUEUE_DEPTH + 5;

	logic       last_in;
	logic       emit;
	logic [3:0] open_q;

	assign last_in = blk_valid && !blk_stall && last_block;
	assign emit    = total_valid && !total_stall;

	// Streams whose total has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (last_in && !emit) begin
			open_q <= open_q + 1'b1;
		end else if (emit && !last_in) begin
			open_q <= open_q - 1'b1;
		end
	end

	// A stalled total stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_valid && total_stall |=> total_valid)
		else $error("total_valid dropped while stalled");

	// A stalled total holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		total_valid && total_stall |=> $stable(bit_total))
		else $error("bit_total changed while stalled");

	// A total is delivered only for a stream whose last word was accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (open_q != 4'd0))
		else $error("total delivered with no stream ended");

	// Back-pressure keeps the number of open streams within storage.
	assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 4'(MAX_OPEN))
		else $error("more ended streams in flight than storage holds");

endmodule

bind stream_bit_population_count sbpc_checker u_sbpc_checker (.*);
